// ===== rtl/tlf_pkg.sv =====
// Shared types and constants for the text line filter.
// Holds the command passed from the front end to the back end through the queue.
// No dependencies.
package tlf_pkg;

    localparam int TLF_DIGITS   = 6;
    localparam int TLF_BCD_W    = 4 * TLF_DIGITS;
    localparam int TLF_MAX_EMIT = TLF_DIGITS + 5;
    localparam int TLF_STEP_W   = $clog2(TLF_MAX_EMIT);
    localparam int TLF_DIG_IW   = (TLF_DIGITS > 1) ? $clog2(TLF_DIGITS) : 1;
    localparam int TLF_BODY_MAX = 4;
    localparam int TLF_BODY_IW  = 2;
    localparam int TLF_BODY_CW  = 3;
    localparam int TLF_QDEPTH   = 4;
    localparam int TLF_QPTR_W   = 2;
    localparam int TLF_QCNT_W   = 3;
    localparam int TLF_OPT_W    = 6;

    // Bit positions in the option register.
    localparam int OPT_NONBLANK = 0;
    localparam int OPT_ENDS     = 1;
    localparam int OPT_NUMBER   = 2;
    localparam int OPT_SQUEEZE  = 3;
    localparam int OPT_TABS     = 4;
    localparam int OPT_NONPRINT = 5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_CARET_OFS = 8'h40;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic                               prefix;
        logic [TLF_BCD_W-1:0]               digits;
        logic [TLF_BODY_MAX-1:0][7:0]       body;
        logic [TLF_STEP_W-1:0]              last_step;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/tlf_front.sv =====
// Front end of the text line filter: accepts bytes, tracks line state and the
// line counter, and turns each kept byte into one command. Depends on tlf_pkg.
module tlf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_data,
    input  logic                  i_accept,
    input  logic [7:0]            i_in_byte,
    output logic                  o_push,
    output tlf_pkg::t_cmd         o_cmd
);
    import tlf_pkg::*;

    logic [TLF_OPT_W-1:0] r_opt;
    logic                 r_at_start, n_at_start;
    logic [1:0]           r_blank_run, n_blank_run;
    logic [TLF_BCD_W-1:0] r_bcd, n_bcd, bcd_inc;

    logic                           blank, drop, pfx_path, prefix;
    logic [TLF_BODY_MAX-1:0][7:0]   body;
    logic [TLF_BODY_CW-1:0]         body_cnt;
    logic [7:0]                     low7, tail0, tail1;
    logic [TLF_BODY_CW-1:0]         tail_cnt;
    logic [TLF_STEP_W-1:0]          pre_len;
    logic [TLF_DIGITS:0]            carry;

    assign blank = (i_in_byte == CH_LF);

    always_comb begin
        n_blank_run = r_blank_run;
        if (r_at_start) begin
            if (blank) begin
                n_blank_run = (r_blank_run == 2'd3) ? 2'd3 : r_blank_run + 2'd1;
            end else begin
                n_blank_run = 2'd0;
            end
        end
    end

    assign drop     = r_at_start && r_opt[OPT_SQUEEZE] && blank && (n_blank_run > 2'd1);
    assign pfx_path = r_at_start && !(blank && r_opt[OPT_NONBLANK]);
    assign prefix   = pfx_path && (r_opt[OPT_NONBLANK] || r_opt[OPT_NUMBER]);

    // Ripple increment of the BCD counter; a digit rolls only when all lower
    // digits are nine. The all-nines value holds.
    always_comb begin
        carry[0] = 1'b1;
        for (int i = 0; i < TLF_DIGITS; i++) begin
            if (carry[i]) begin
                bcd_inc[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd9) ? 4'd0 : r_bcd[4*i +: 4] + 4'd1;
            end else begin
                bcd_inc[4*i +: 4] = r_bcd[4*i +: 4];
            end
            carry[i+1] = carry[i] && (r_bcd[4*i +: 4] >= 4'd9);
        end
    end

    // Visible form of the low seven bits, used for non-printing escapes.
    always_comb begin
        low7     = {1'b0, i_in_byte[6:0]};
        tail0    = low7;
        tail1    = '0;
        tail_cnt = TLF_BODY_CW'(1);
        if (low7 < 8'd32) begin
            tail0    = CH_CARET;
            tail1    = low7 + CH_CARET_OFS;
            tail_cnt = TLF_BODY_CW'(2);
        end else if (low7 == CH_DEL) begin
            tail0    = CH_CARET;
            tail1    = CH_QMARK;
            tail_cnt = TLF_BODY_CW'(2);
        end
    end

    always_comb begin
        body     = '0;
        body_cnt = TLF_BODY_CW'(1);
        if (blank) begin
            if (r_opt[OPT_ENDS]) begin
                body[0]  = CH_DOLLAR;
                body[1]  = CH_LF;
                body_cnt = TLF_BODY_CW'(2);
            end else begin
                body[0] = CH_LF;
            end
        end else if (i_in_byte == CH_TAB) begin
            if (r_opt[OPT_TABS]) begin
                body[0]  = CH_CARET;
                body[1]  = CH_I;
                body_cnt = TLF_BODY_CW'(2);
            end else begin
                body[0] = CH_TAB;
            end
        end else if (r_opt[OPT_NONPRINT]) begin
            if (i_in_byte[7]) begin
                body[0]  = CH_M;
                body[1]  = CH_DASH;
                body[2]  = tail0;
                body[3]  = tail1;
                body_cnt = tail_cnt + TLF_BODY_CW'(2);
            end else begin
                body[0]  = tail0;
                body[1]  = tail1;
                body_cnt = tail_cnt;
            end
        end else begin
            body[0] = i_in_byte;
        end
    end

    assign pre_len = prefix ? TLF_STEP_W'(TLF_DIGITS + 1) : '0;

    assign o_push          = i_accept && !drop;
    assign o_cmd.prefix    = prefix;
    assign o_cmd.digits    = r_bcd;
    assign o_cmd.body      = body;
    assign o_cmd.last_step = pre_len + TLF_STEP_W'(body_cnt) - TLF_STEP_W'(1);

    always_comb begin
        n_at_start = r_at_start;
        n_bcd      = r_bcd;
        if (!drop) begin
            n_at_start = blank;
            if (pfx_path) begin
                n_bcd = carry[TLF_DIGITS] ? r_bcd : bcd_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt       <= '0;
            r_at_start  <= 1'b1;
            r_blank_run <= 2'd0;
            r_bcd       <= TLF_BCD_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_opt <= i_cfg_data;
            end
            if (i_accept) begin
                r_at_start  <= n_at_start;
                r_blank_run <= n_blank_run;
                r_bcd       <= n_bcd;
            end
        end
    end

endmodule

// ===== rtl/tlf_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Register array with one read address. Depends on tlf_pkg.
module tlf_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tlf_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output tlf_pkg::t_cmd       o_head,
    output tlf_pkg::t_q_stat    o_stat
);
    import tlf_pkg::*;

    t_cmd                  r_mem [TLF_QDEPTH];
    logic [TLF_QPTR_W-1:0] r_wr, r_rd;
    logic [TLF_QCNT_W-1:0] r_cnt;
    logic                  do_push, do_pop;

    assign o_stat.full  = (r_cnt == TLF_QCNT_W'(TLF_QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + TLF_QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + TLF_QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + TLF_QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - TLF_QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tlf_back.sv =====
// Back end of the text line filter: walks the queue head one output byte per
// cycle into the output register when it is free. Depends on tlf_pkg.
module tlf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlf_pkg::t_cmd       i_head,
    input  tlf_pkg::t_q_stat    i_stat,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run
);
    import tlf_pkg::*;

    logic [TLF_STEP_W-1:0] r_step;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;

    logic                  out_free, adv, is_last;
    logic [TLF_STEP_W-1:0] dig_pos, body_ofs;
    logic [TLF_DIG_IW-1:0] dig_idx;
    logic [TLF_BODY_IW-1:0] body_idx;
    logic [TLF_DIGITS-1:0] lead;
    logic                  zero_above;
    logic [3:0]            digit;
    logic [7:0]            byte_sel;

    // A digit prints as a space while it and all higher digits are zero,
    // except the lowest digit, which always prints.
    always_comb begin
        zero_above = 1'b1;
        for (int j = TLF_DIGITS - 1; j >= 0; j--) begin
            zero_above = zero_above && (i_head.digits[4*j +: 4] == 4'd0);
            lead[j]    = zero_above && (j != 0);
        end
    end

    assign dig_pos  = TLF_STEP_W'(TLF_DIGITS - 1) - r_step;
    assign dig_idx  = dig_pos[TLF_DIG_IW-1:0];
    assign digit    = i_head.digits[4*dig_idx +: 4];
    assign body_ofs = r_step - (i_head.prefix ? TLF_STEP_W'(TLF_DIGITS + 1) : '0);
    assign body_idx = body_ofs[TLF_BODY_IW-1:0];

    always_comb begin
        if (i_head.prefix && (r_step < TLF_STEP_W'(TLF_DIGITS))) begin
            byte_sel = lead[dig_idx] ? CH_SPACE : (CH_ZERO | {4'd0, digit});
        end else if (i_head.prefix && (r_step == TLF_STEP_W'(TLF_DIGITS))) begin
            byte_sel = CH_TAB;
        end else begin
            byte_sel = i_head.body[body_idx];
        end
    end

    assign out_free = !r_out_valid || i_pop;
    assign adv      = out_free && !i_stat.empty;
    assign is_last  = (r_step == i_head.last_step);
    assign o_q_pop  = adv && is_last;

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= byte_sel;
            r_out_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_step      <= is_last ? '0 : r_step + TLF_STEP_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/text_line_filter_escape_number.sv =====
// Top level of the text line filter with numbering, squeezing and escapes.
// Instantiates tlf_front, tlf_cmd_fifo and tlf_back; depends on tlf_pkg.
//
//  Channel   Handshake           Payload
//  input     push / full         i_in_byte
//  result    empty / pop         o_out_byte, o_last_of_run
//  config    i_cfg_we            i_cfg_data (option bits)
//
// The front end takes one byte per cycle while the four-entry command queue
// has room. The back end emits one output byte per cycle while its output
// register is free; an input byte produces 1 output byte for plain text, 2 to
// 4 for escapes, plus 7 for a line number prefix. A squeezed blank line is
// accepted and gives no output. Reset is synchronous and restores line start,
// counter value one and all options off. A stalled pop holds the result.
module text_line_filter_escape_number (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);
    import tlf_pkg::*;

    t_cmd    front_cmd, q_head;
    t_q_stat q_stat;
    logic    q_push, q_pop, accept;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    tlf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    tlf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    tlf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_stat        (q_stat),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // The front end never writes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // Retiring a command always loads its final byte into the output register.
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (!empty && o_last_of_run))
        else $error("queue pop without a final output byte");

    // A waiting result that is not taken stays available.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

    // The back end only retires a command that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for text_line_filter_escape_number.
// Depends on tlf_pkg and the filter RTL; a built-in predictor supplies the expected bytes.
// Covers directed escapes, numbering, squeeze, random text, back-pressure and numbered lines.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlf_pkg::*;

    localparam logic [5:0] M_NONBLANK = 6'b1 << OPT_NONBLANK;
    localparam logic [5:0] M_ENDS     = 6'b1 << OPT_ENDS;
    localparam logic [5:0] M_NUMBER   = 6'b1 << OPT_NUMBER;
    localparam logic [5:0] M_SQUEEZE  = 6'b1 << OPT_SQUEEZE;
    localparam logic [5:0] M_TABS     = 6'b1 << OPT_TABS;
    localparam logic [5:0] M_NONPRINT = 6'b1 << OPT_NONPRINT;
    localparam logic [5:0] M_ALL      = 6'h3F;

    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 120;
    localparam int RANDOM_ITEMS  = 50;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [5:0] i_cfg_data = '0;
    logic       push = 1'b0;
    logic [7:0] i_in_byte = '0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    // Result handshake as it stands just before the next rising edge.
    logic       smp_take;
    logic [7:0] smp_byte;
    logic       smp_last;

    // Predictor state, mirrors the filter's registers.
    logic [5:0]           opt_model = '0;
    logic                 line_open_pending = 1'b1;
    logic [1:0]           blank_cnt = '0;
    logic [TLF_BCD_W-1:0] line_num = TLF_BCD_W'(1);

    t_out_rec expected_q[$];
    int       err_count = 0;
    int       cycle_count = 0;
    int       items_sent = 0;
    int       rx_hold = 0;
    bit       gaps_on = 1'b1;
    bit       stalls_on = 1'b1;
    bit       long_hold_req = 1'b0;

    text_line_filter_escape_number DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Works out the filtered bytes for one accepted input byte.
    task automatic predict_filter(input logic [7:0] c);
        logic [7:0] emit_buf [TLF_MAX_EMIT];
        int         n;
        int         i;
        bit         blank;
        bit         lead;
        bit         carry;
        logic [3:0] d;
        logic [7:0] v;
        n = 0;
        if (line_open_pending) begin
            blank = (c == CH_LF);
            if (blank) begin
                if (blank_cnt != 2'd3)
                    blank_cnt++;
            end else begin
                blank_cnt = '0;
            end
            // A dropped blank line leaves the line start pending.
            if (opt_model[OPT_SQUEEZE] && blank && blank_cnt > 2'd1)
                return;
            if (!(blank && opt_model[OPT_NONBLANK])) begin
                if (opt_model[OPT_NONBLANK] || opt_model[OPT_NUMBER]) begin
                    lead = 1'b1;
                    for (i = TLF_DIGITS - 1; i >= 0; i--) begin
                        d = line_num[4*i +: 4];
                        if (d != 4'd0 || i == 0)
                            lead = 1'b0;
                        emit_buf[n] = lead ? CH_SPACE : CH_ZERO + 8'(d);
                        n++;
                    end
                    emit_buf[n] = CH_TAB;
                    n++;
                end
                if (line_num != {TLF_DIGITS{4'h9}}) begin
                    carry = 1'b1;
                    for (i = 0; i < TLF_DIGITS; i++) begin
                        if (carry) begin
                            if (line_num[4*i +: 4] >= 4'd9) begin
                                line_num[4*i +: 4] = 4'd0;
                            end else begin
                                line_num[4*i +: 4] = line_num[4*i +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
            end
            line_open_pending = 1'b0;
        end

        if (c == CH_LF) begin
            if (opt_model[OPT_ENDS]) begin
                emit_buf[n] = CH_DOLLAR;
                n++;
            end
            emit_buf[n] = CH_LF;
            n++;
            line_open_pending = 1'b1;
        end else if (c == CH_TAB) begin
            if (opt_model[OPT_TABS]) begin
                emit_buf[n] = CH_CARET;
                emit_buf[n+1] = CH_I;
                n += 2;
            end else begin
                emit_buf[n] = CH_TAB;
                n++;
            end
        end else if (opt_model[OPT_NONPRINT]) begin
            v = c;
            if (v[7]) begin
                emit_buf[n] = CH_M;
                emit_buf[n+1] = CH_DASH;
                n += 2;
                v[7] = 1'b0;
            end
            if (v < 8'd32) begin
                emit_buf[n] = CH_CARET;
                emit_buf[n+1] = v + CH_CARET_OFS;
                n += 2;
            end else if (v == CH_DEL) begin
                emit_buf[n] = CH_CARET;
                emit_buf[n+1] = CH_QMARK;
                n += 2;
            end else begin
                emit_buf[n] = v;
                n++;
            end
        end else begin
            emit_buf[n] = c;
            n++;
        end

        for (i = 0; i < n; i++)
            expected_q.push_back('{ch: emit_buf[i], last: (i == n - 1)});
    endtask

    // Pop, empty and the result ports only change at rising edges, so the
    // values at the falling edge are the ones the next rising edge sees.
    always @(negedge i_clk) begin
        smp_take = pop && !empty;
        smp_byte = o_out_byte;
        smp_last = o_last_of_run;
    end

    // Result side: checks each accepted byte and plans the next pop.
    always @(posedge i_clk) begin : result_side
        int r;
        if (!i_rst_n) begin
            pop <= 1'b0;
            rx_hold = 0;
        end else begin
            if (smp_take) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte 0x%02h", smp_byte));
                end else begin
                    if (smp_byte !== expected_q[0].ch)
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  smp_byte, expected_q[0].ch));
                    if (smp_last !== expected_q[0].last)
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  smp_last, expected_q[0].last));
                    void'(expected_q.pop_front());
                end
            end
            if (long_hold_req) begin
                rx_hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (rx_hold > 0) begin
                pop <= 1'b0;
                rx_hold--;
            end else if (!stalls_on || $urandom_range(0, 99) < 60) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                r = $urandom_range(0, 9);
                rx_hold = (r < 8) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Push stays high after acceptance so back-to-back requests need no extra step.
    // Full is read at the falling edge ahead of the edge that accepts the request.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        @(negedge i_clk);
        while (full)
            @(negedge i_clk);
        @(posedge i_clk);
        predict_filter(b);
        items_sent++;
    endtask

    // A squeezed newline gives no output, so drain the expected bytes and then let the filter settle.
    task automatic drain_results();
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [5:0] opts);
        drain_results();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= opts;
        @(posedge i_clk);
        opt_model = opts;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_line();
        int kind;
        int len;
        int p;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            send_byte(CH_LF);
        end else if (kind < 30) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            len = $urandom_range(0, 10);
            repeat (len) begin
                p = $urandom_range(0, 99);
                if (p < 50)
                    send_byte(8'($urandom_range(32, 126)));
                else if (p < 62)
                    send_byte(CH_TAB);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            send_byte(CH_LF);
        end
    endtask

    task automatic test_plain_bytes();
        start_phase('0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_TAB);
        send_byte(CH_DEL);
        send_byte(CH_LF);
    endtask

    task automatic test_escapes();
        start_phase(M_NONPRINT | M_TABS | M_ENDS);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(8'h80);
        send_byte(8'h9F);
        send_byte(8'hFF);
        send_byte(CH_TAB);
        send_byte(8'h41);
        send_byte(CH_LF);
    endtask

    // Four blank lines in a row: the run saturates and the later ones are dropped.
    task automatic test_numbered_squeeze();
        start_phase(M_NUMBER | M_SQUEEZE);
        repeat (4) send_byte(CH_LF);
        send_byte(8'h41);
        send_byte(CH_LF);
    endtask

    // Every option on: nonblank numbering wins on blank lines.
    task automatic test_all_options();
        start_phase(M_ALL);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(8'h7E);
        send_byte(CH_LF);
    endtask

    task automatic test_backpressure();
        int i;
        start_phase(M_NUMBER | M_NONPRINT);
        gaps_on = 1'b0;
        @(negedge i_clk);
        long_hold_req = 1'b1;
        @(posedge i_clk);
        for (i = 0; i < 24; i++)
            send_byte((i % 6 == 5) ? CH_LF : 8'($urandom_range(0, 255)));
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_text();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            start_phase(6'($urandom_range(0, 63)));
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 6)) send_random_line();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Numbered blank lines with line ends shown, counting on from the current line.
    task automatic test_counter_carry();
        start_phase(M_NUMBER | M_ENDS);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (12) send_byte(CH_LF);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_bytes();
        test_escapes();
        test_numbered_squeeze();
        test_all_options();
        test_backpressure();
        test_random_text();
        test_counter_carry();
        drain_results();
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
